### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle out of reset
`define CHK_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// implication checked on the following cycle
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

### rtl/pps_pkg.sv
package pps_pkg;

   localparam int DefQueueDepth = 16;
   localparam int InQDepth      = 2;
   localparam int OutQDepth     = 4;

   // one arrival as it travels from the front to the back
   typedef struct packed {
      logic [7:0]  proc_id;
      logic [15:0] arrival_time;
      logic [15:0] burst_length;
      logic [7:0]  priority_req;
      logic        final_arrival;
   } req_type;

   // one gantt segment or drop notice
   typedef struct packed {
      logic [7:0]  seg_id;
      logic [31:0] seg_start;
      logic [31:0] seg_length;
      logic        dropped;
      logic        last_result;
   } rsp_type;

   // queue entry
   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] arr;
      logic [15:0] rem;
      logic [7:0]  pri;
   } job_type;

   // true when candidate c beats incumbent w
   function automatic logic job_better(job_type c, job_type w);
      logic r;
      if (c.pri != w.pri) begin
         r = c.pri > w.pri;
      end else if (c.arr != w.arr) begin
         r = c.arr < w.arr;
      end else begin
         r = c.id < w.id;
      end
      return r;
   endfunction

endpackage

### rtl/preemptive_priority_scheduler.sv
// preemptive priority scheduler producing merged gantt segments
// input queue: drive req_* and push; a request is taken when push is high
// and full is low. arrivals must come in nondecreasing arrival_time.
// result queue: while empty is low the oldest segment sits on rsp_*; pop
// takes it. each request yields zero or more results, the last one of
// them flagged by rsp_last_result; a dropped arrival gives rsp_dropped.
// a two-entry request queue feeds the scheduling engine, and a small
// result queue decouples the engine from a stalled receiver; a full
// result queue stalls the engine when it has a result to pass on.
// timing: each selection walks the ready queue one entry per cycle (at
// most QUEUE_DEPTH-1 entries), then runs the winner and, if the winner
// finishes, compacts the queue over its slot; a request repeats this
// for each run it causes, then inserts or drops the arrival, and a
// final arrival also drains the queue and flushes the open segment.
// reset clears the queues, the scheduler clock and the open segment;
// ready queue contents are not cleared, the fill count guards them.
`include "assert_macros.svh"
module preemptive_priority_scheduler
   import pps_pkg::*;
#(
   parameter int QUEUE_DEPTH = DefQueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_proc_id,
   input  logic [15:0] req_arrival_time,
   input  logic [15:0] req_burst_length,
   input  logic [7:0]  req_priority_req,
   input  logic        req_final_arrival,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_seg_id,
   output logic [31:0] rsp_seg_start,
   output logic [31:0] rsp_seg_length,
   output logic        rsp_dropped,
   output logic        rsp_last_result
);
   req_type in_w, in_r;
   rsp_type ep_rsp, out_r;
   logic    in_empty, take, ep_push, oq_full, busy;

   assign in_w = '{proc_id: req_proc_id, arrival_time: req_arrival_time,
                   burst_length: req_burst_length, priority_req: req_priority_req,
                   final_arrival: req_final_arrival};

   // front request queue
   pps_fifo #(.Width($bits(req_type)), .Depth(InQDepth)) u_inq (
      .clock(clock), .reset(reset), .wr(push), .wdata(in_w), .full(full),
      .rd(take), .rdata(in_r), .empty(in_empty));

   // scheduling engine
   pps_engine #(.QueueDepth(QUEUE_DEPTH)) u_eng (
      .clock(clock), .reset(reset), .in_valid(!in_empty), .in_req(in_r),
      .in_take(take), .out_push(ep_push), .out_rsp(ep_rsp), .out_full(oq_full),
      .busy(busy));

   // result queue
   pps_fifo #(.Width($bits(rsp_type)), .Depth(OutQDepth)) u_outq (
      .clock(clock), .reset(reset), .wr(ep_push), .wdata(ep_rsp), .full(oq_full),
      .rd(pop), .rdata(out_r), .empty(empty));

   assign rsp_seg_id      = out_r.seg_id;
   assign rsp_seg_start   = out_r.seg_start;
   assign rsp_seg_length  = out_r.seg_length;
   assign rsp_dropped     = out_r.dropped;
   assign rsp_last_result = out_r.last_result;

   `CHK_IMPL(a_no_lost_push, clock, reset, ep_push, !oq_full)
   `CHK_IMPL(a_take_idle, clock, reset, take, !in_empty)
   `CHK_NEXT(a_take_busy, clock, reset, take, busy)
endmodule

### rtl/pps_fifo.sv
module pps_fifo
   import pps_pkg::*;
#(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr,
   input  logic [Width-1:0] wdata,
   output logic             full,
   input  logic             rd,
   output logic [Width-1:0] rdata,
   output logic             empty
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   logic [Width-1:0] mem_ff [Depth];
   logic [AW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_wr, do_rd;

   assign full  = cnt_ff == (AW+1)'(Depth);
   assign empty = cnt_ff == '0;
   assign do_wr = wr && !full;
   assign do_rd = rd && !empty;
   assign rdata = mem_ff[rp_ff];

   // pointer and count update
   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_wr) begin
         wp_in = (wp_ff == AW'(Depth-1)) ? '0 : wp_ff + 1'b1;
      end
      if (do_rd) begin
         rp_in = (rp_ff == AW'(Depth-1)) ? '0 : rp_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wp_ff] <= wdata;
      end
   end
endmodule

### rtl/pps_engine.sv
module pps_engine
   import pps_pkg::*;
#(
   parameter int QueueDepth = DefQueueDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_req,
   output logic    in_take,
   output logic    out_push,
   output rsp_type out_rsp,
   input  logic    out_full,
   output logic    busy
);
   localparam int IW = $clog2(QueueDepth);
   localparam int CW = $clog2(QueueDepth + 1);
   localparam logic [CW-1:0] Usable = CW'(QueueDepth - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_RUN   = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_INS   = 3'd4;
   localparam logic [2:0] S_FLUSH = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   job_type       q_ff [QueueDepth];
   logic [2:0]    st_ff;
   req_type       cur_ff;
   logic [CW-1:0] cnt_ff;
   logic [IW-1:0] idx_ff, best_ff;
   job_type       bj_ff;
   logic          drain_ff;
   logic [31:0]   clk_ff;
   logic [7:0]    oid_ff;
   logic [31:0]   ost_ff, olen_ff;
   logic          oval_ff;
   // one result held back so last_result can be set on the final one
   rsp_type       hold_ff;
   logic          hval_ff;

   logic [31:0]   arr32, jarr32, start, slot, len;
   logic          emit;
   rsp_type       emit_rsp;
   logic          stall;

   assign arr32  = {16'd0, cur_ff.arrival_time};
   assign jarr32 = {16'd0, bj_ff.arr};
   assign start  = (clk_ff < jarr32) ? jarr32 : clk_ff;
   assign slot   = arr32 - start;
   assign busy   = st_ff != S_IDLE || hval_ff;
   assign in_take = st_ff == S_IDLE && in_valid && !hval_ff;
   // any new result pushes out the held one
   assign stall  = hval_ff && out_full;

   // work out whether this step produces a result
   always_comb begin
      emit     = 1'b0;
      emit_rsp = '0;
      case (st_ff)
         S_RUN: begin
            if ((drain_ff || jarr32 < arr32) && oval_ff && oid_ff != bj_ff.id) begin
               emit = 1'b1;
            end
            emit_rsp.seg_id     = oid_ff;
            emit_rsp.seg_start  = ost_ff;
            emit_rsp.seg_length = olen_ff;
         end
         S_INS: begin
            emit = cnt_ff >= Usable;
            emit_rsp.dropped = 1'b1;
         end
         S_FLUSH: begin
            emit = oval_ff;
            emit_rsp.seg_id     = oid_ff;
            emit_rsp.seg_start  = ost_ff;
            emit_rsp.seg_length = olen_ff;
         end
         default: emit = 1'b0;
      endcase
   end

   assign len = (drain_ff || {16'd0, bj_ff.rem} <= slot) ? {16'd0, bj_ff.rem} : slot;
   assign out_push = hval_ff && ((emit && !stall) || (st_ff == S_DONE && !out_full));
   always_comb begin
      out_rsp = hold_ff;
      out_rsp.last_result = st_ff == S_DONE;
   end

   // control and datapath sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         cnt_ff  <= '0;
         clk_ff  <= '0;
         oid_ff  <= '0;
         ost_ff  <= '0;
         olen_ff <= '0;
         oval_ff <= 1'b0;
         hval_ff <= 1'b0;
         drain_ff <= 1'b0;
      end else if (!stall || !emit) begin
         if (emit) begin
            hold_ff <= emit_rsp;
            hval_ff <= 1'b1;
         end
         case (st_ff)
            S_IDLE: begin
               if (in_take) begin
                  cur_ff   <= in_req;
                  drain_ff <= 1'b0;
                  st_ff    <= S_SCAN;
                  idx_ff   <= '0;
               end
            end
            S_SCAN: begin
               // walk entries one per cycle keeping the best
               if (cnt_ff == '0 || (!drain_ff && clk_ff >= arr32)) begin
                  st_ff <= drain_ff ? S_FLUSH : S_INS;
               end else if (idx_ff == '0) begin
                  bj_ff   <= q_ff[0];
                  best_ff <= '0;
                  if (cnt_ff == CW'(1)) begin
                     st_ff <= S_RUN;
                  end else begin
                     idx_ff <= IW'(1);
                  end
               end else begin
                  if (job_better(q_ff[idx_ff], bj_ff)) begin
                     bj_ff   <= q_ff[idx_ff];
                     best_ff <= idx_ff;
                  end
                  if (CW'(idx_ff) == cnt_ff - 1'b1) begin
                     st_ff <= S_RUN;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            S_RUN: begin
               if (!drain_ff && jarr32 >= arr32) begin
                  st_ff <= S_INS;
               end else begin
                  if (oval_ff && oid_ff == bj_ff.id) begin
                     olen_ff <= olen_ff + len;
                  end else begin
                     oid_ff  <= bj_ff.id;
                     ost_ff  <= start;
                     olen_ff <= len;
                     oval_ff <= 1'b1;
                  end
                  clk_ff <= start + len;
                  idx_ff <= '0;
                  if (drain_ff || {16'd0, bj_ff.rem} <= slot) begin
                     idx_ff <= best_ff;
                     st_ff  <= S_SHIFT;
                  end else begin
                     q_ff[best_ff].rem <= bj_ff.rem - slot[15:0];
                     st_ff <= S_SCAN;
                  end
               end
            end
            S_SHIFT: begin
               // compact one slot per cycle
               if (CW'(idx_ff) + 1'b1 >= cnt_ff) begin
                  cnt_ff <= cnt_ff - 1'b1;
                  idx_ff <= '0;
                  st_ff  <= S_SCAN;
               end else begin
                  q_ff[idx_ff] <= q_ff[idx_ff + 1'b1];
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_INS: begin
               if (cnt_ff < Usable) begin
                  q_ff[cnt_ff[IW-1:0]] <= {cur_ff.proc_id, cur_ff.arrival_time,
                                           cur_ff.burst_length, cur_ff.priority_req};
                  cnt_ff <= cnt_ff + 1'b1;
               end
               idx_ff <= '0;
               if (cur_ff.final_arrival) begin
                  drain_ff <= 1'b1;
                  st_ff    <= S_SCAN;
               end else begin
                  st_ff <= S_DONE;
               end
            end
            S_FLUSH: begin
               oid_ff  <= '0;
               ost_ff  <= '0;
               olen_ff <= '0;
               oval_ff <= 1'b0;
               clk_ff  <= '0;
               st_ff   <= S_DONE;
            end
            S_DONE: begin
               if (!hval_ff || !out_full) begin
                  hval_ff <= 1'b0;
                  st_ff   <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
   import pps_pkg::*;

   localparam int QDepth      = DefQueueDepth;
   localparam int RandItems   = 185;
   localparam int IdleLimit   = 20000;
   localparam int DrainCycles = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_proc_id = '0;
   logic [15:0] req_arrival_time = '0;
   logic [15:0] req_burst_length = '0;
   logic [7:0]  req_priority_req = '0;
   logic        req_final_arrival = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_seg_id;
   logic [31:0] rsp_seg_start;
   logic [31:0] rsp_seg_length;
   logic        rsp_dropped;
   logic        rsp_last_result;

   preemptive_priority_scheduler #(.QUEUE_DEPTH(QDepth)) u_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_proc_id(req_proc_id), .req_arrival_time(req_arrival_time),
      .req_burst_length(req_burst_length), .req_priority_req(req_priority_req),
      .req_final_arrival(req_final_arrival), .empty(empty), .pop(pop),
      .rsp_seg_id(rsp_seg_id), .rsp_seg_start(rsp_seg_start),
      .rsp_seg_length(rsp_seg_length), .rsp_dropped(rsp_dropped),
      .rsp_last_result(rsp_last_result)
   );

   always #2 clock = ~clock;

   // pending requests and expected gantt segments
   req_type     pending_reqs[$];
   rsp_type     expected_segs[$];
   int          n_sent = 0;
   int          n_total = 0;
   int          n_segs = 0;
   int          n_drops = 0;
   int          n_batches = 0;
   int          n_errors = 0;
   int          hold_at = 100;
   logic        quiet = 1'b0;

   // scheduler model state
   job_type     ready_jobs[QDepth];
   int          job_count = 0;
   logic [31:0] cpu_tick = '0;
   logic [7:0]  cur_id = '0;
   logic [31:0] cur_start = '0;
   logic [31:0] cur_len = '0;
   logic        cur_open = 1'b0;

   function automatic int best_job();
      int b;
      b = 0;
      for (int i = 1; i < job_count; i++) begin
         if (ready_jobs[i].pri != ready_jobs[b].pri) begin
            if (ready_jobs[i].pri > ready_jobs[b].pri) b = i;
         end else if (ready_jobs[i].arr != ready_jobs[b].arr) begin
            if (ready_jobs[i].arr < ready_jobs[b].arr) b = i;
         end else if (ready_jobs[i].id < ready_jobs[b].id) begin
            b = i;
         end
      end
      return b;
   endfunction

   task automatic retire_job(int k);
      for (int i = k; i + 1 < job_count; i++) ready_jobs[i] = ready_jobs[i + 1];
      job_count--;
   endtask

   task automatic emit_seg(logic [7:0] id, logic [31:0] st, logic [31:0] len, logic drop);
      rsp_type r;
      r.seg_id = id;
      r.seg_start = st;
      r.seg_length = len;
      r.dropped = drop;
      r.last_result = 1'b0;
      expected_segs = {expected_segs, r};
   endtask

   task automatic log_run(logic [7:0] id, logic [31:0] st, logic [31:0] len);
      if (cur_open && cur_id == id) begin
         cur_len = cur_len + len;
      end else begin
         if (cur_open) emit_seg(cur_id, cur_start, cur_len, 1'b0);
         cur_id = id;
         cur_start = st;
         cur_len = len;
         cur_open = 1'b1;
      end
   endtask

   // advance the cpu to the arrival, queue it or drop it when the queue is full, drain on the final one
   task automatic schedule_arrival(req_type q);
      int k;
      int base;
      logic [31:0] arr;
      logic [31:0] slot;
      rsp_type r;
      base = expected_segs.size();
      arr = {16'b0, q.arrival_time};
      while (job_count > 0 && cpu_tick < arr) begin
         k = best_job();
         if ({16'b0, ready_jobs[k].arr} >= arr) break;
         if (cpu_tick < {16'b0, ready_jobs[k].arr}) cpu_tick = {16'b0, ready_jobs[k].arr};
         slot = arr - cpu_tick;
         if ({16'b0, ready_jobs[k].rem} <= slot) begin
            log_run(ready_jobs[k].id, cpu_tick, {16'b0, ready_jobs[k].rem});
            cpu_tick = cpu_tick + {16'b0, ready_jobs[k].rem};
            retire_job(k);
         end else begin
            log_run(ready_jobs[k].id, cpu_tick, slot);
            ready_jobs[k].rem = ready_jobs[k].rem - slot[15:0];
            cpu_tick = arr;
         end
      end
      if (job_count < QDepth - 1) begin
         ready_jobs[job_count].id = q.proc_id;
         ready_jobs[job_count].arr = q.arrival_time;
         ready_jobs[job_count].rem = q.burst_length;
         ready_jobs[job_count].pri = q.priority_req;
         job_count++;
      end else begin
         emit_seg('0, '0, '0, 1'b1);
         n_drops++;
      end
      if (q.final_arrival) begin
         while (job_count > 0) begin
            k = best_job();
            if (cpu_tick < {16'b0, ready_jobs[k].arr}) cpu_tick = {16'b0, ready_jobs[k].arr};
            log_run(ready_jobs[k].id, cpu_tick, {16'b0, ready_jobs[k].rem});
            cpu_tick = cpu_tick + {16'b0, ready_jobs[k].rem};
            retire_job(k);
         end
         if (cur_open) emit_seg(cur_id, cur_start, cur_len, 1'b0);
         cur_id = '0;
         cur_start = '0;
         cur_len = '0;
         cur_open = 1'b0;
         cpu_tick = '0;
         n_batches++;
      end
      if (expected_segs.size() > base) begin
         r = expected_segs.pop_back();
         r.last_result = 1'b1;
         expected_segs = {expected_segs, r};
      end
   endtask

   function automatic req_type mk_req(int id, int t, int b, int p, int fin);
      req_type q;
      q.proc_id = id[7:0];
      q.arrival_time = t[15:0];
      q.burst_length = b[15:0];
      q.priority_req = p[7:0];
      q.final_arrival = fin[0];
      return q;
   endfunction

   // request driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            schedule_arrival(pending_reqs.pop_front());
            n_sent++;
         end
         if (send_gap > 0) send_gap--;
         if (pending_reqs.size() == 0 || send_gap > 0) begin
            push <= 1'b0;
         end else if (n_sent == hold_at && expected_segs.size() != 0) begin
            push <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 13);
            push <= 1'b0;
         end else begin
            push <= 1'b1;
            req_proc_id <= pending_reqs[0].proc_id;
            req_arrival_time <= pending_reqs[0].arrival_time;
            req_burst_length <= pending_reqs[0].burst_length;
            req_priority_req <= pending_reqs[0].priority_req;
            req_final_arrival <= pending_reqs[0].final_arrival;
         end
      end
   end

   // result monitor and checker
   int pop_gap = 0;
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            got = '{rsp_seg_id, rsp_seg_start, rsp_seg_length, rsp_dropped, rsp_last_result};
            n_segs++;
            if (expected_segs.size() == 0) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("unexpected result id=%0d start=%0d len=%0d drop=%0b last=%0b",
                           got.seg_id, got.seg_start, got.seg_length, got.dropped,
                           got.last_result);
            end else begin
               want = expected_segs.pop_front();
               if (got !== want) begin
                  n_errors++;
                  if (n_errors <= 10) begin
                     $display("result %0d: exp id=%0d start=%0d len=%0d drop=%0b last=%0b",
                              n_segs, want.seg_id, want.seg_start, want.seg_length,
                              want.dropped, want.last_result);
                     $display("   got id=%0d start=%0d len=%0d drop=%0b last=%0b",
                              got.seg_id, got.seg_start, got.seg_length, got.dropped,
                              got.last_result);
                  end
               end
            end
         end
         if (pop_gap > 0) begin
            pop_gap--;
            pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            pop_gap = $urandom_range(0, 12);
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // quiet tail: no idling for the last requests
   always @(posedge clock) if (n_sent >= n_total - 30 && n_total > 0) quiet <= 1'b1;

   initial begin
      int t;
      int len;
      int id;
      int pri;
      int bl;
      // directed: preemption, merge, zero burst, extremes
      pending_reqs = {pending_reqs, mk_req(5, 0, 10, 3, 0)};
      pending_reqs = {pending_reqs, mk_req(7, 2, 4, 9, 0)};
      pending_reqs = {pending_reqs, mk_req(9, 2, 0, 9, 0)};
      pending_reqs = {pending_reqs, mk_req(5, 8, 2, 3, 0)};
      pending_reqs = {pending_reqs, mk_req(255, 20, 65535, 255, 0)};
      pending_reqs = {pending_reqs, mk_req(0, 65535, 65535, 0, 1)};
      // directed: identical keys, queue full and drop
      for (int i = 0; i < 16; i++)
         pending_reqs = {pending_reqs, mk_req(i < 2 ? 3 : i, 100, 3 + i,
                                              i < 2 ? 1 : i % 4, i == 15)};
      // random batches, each ended by a final arrival
      while (pending_reqs.size() < 22 + RandItems) begin
         len = $urandom_range(1, 18);
         t = $urandom_range(0, 50);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) t = t + $urandom_range(0, 40000);
            else t = t + $urandom_range(0, 8);
            if (t > 65535) t = 65535;
            id = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 255);
            pri = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2) : $urandom_range(0, 255);
            bl = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 12);
            pending_reqs = {pending_reqs, mk_req(id, t, bl, pri, i == len - 1)};
         end
      end
      n_total = pending_reqs.size();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (pending_reqs.size() == 0);
      wait (expected_segs.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      if (expected_segs.size() != 0) begin
         n_errors++;
         $display("%0d expected results never arrived", expected_segs.size());
      end
      $display("sent %0d arrivals in %0d batches, checked %0d results, %0d drops",
               n_sent, n_batches, n_segs, n_drops);
      if (n_errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
